### hw/rtl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the MIDI stream parser: status byte codes,
// event kinds and the command that passes from the front to the back end.
// ----------------------------------------------------------------------------
package msp_pkg;

   // status bytes
   localparam logic [7:0] ST_SYSEX_START = 8'hF0;
   localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
   localparam logic [7:0] ST_REALTIME    = 8'hF8;
   localparam logic [7:0] RT_CLOCK       = 8'hF8;
   localparam logic [7:0] RT_START       = 8'hFA;
   localparam logic [7:0] RT_CONTINUE    = 8'hFB;
   localparam logic [7:0] RT_STOP        = 8'hFC;

   // voice message types, upper nibble of the status byte
   localparam logic [3:0] MSG_NOTE_OFF    = 4'h8;
   localparam logic [3:0] MSG_NOTE_ON     = 4'h9;
   localparam logic [3:0] MSG_POLY_PRESS  = 4'hA;
   localparam logic [3:0] MSG_CTRL_CHANGE = 4'hB;
   localparam logic [3:0] MSG_PROG_CHANGE = 4'hC;
   localparam logic [3:0] MSG_CHAN_PRESS  = 4'hD;
   localparam logic [3:0] MSG_PITCH_BEND  = 4'hE;

   // width of a sysex run length, enough for a store of up to 127 bytes
   localparam int unsigned LEN_W = 7;

   typedef enum logic [2:0] {
      EV_NOTE_ON   = 3'd0,
      EV_NOTE_OFF  = 3'd1,
      EV_CTRL      = 3'd2,
      EV_CLOCK     = 3'd3,
      EV_START     = 3'd4,
      EV_CONTINUE  = 3'd5,
      EV_STOP      = 3'd6,
      EV_SYSEX     = 3'd7
   } event_kind_type;

   // one queued command: a single event or a sysex drain
   typedef struct packed {
      logic                is_drain;
      event_kind_type      kind;
      logic [4:0]          chan;
      logic [6:0]          key;
      logic [6:0]          val;
      logic [LEN_W-1:0]    len;
   } cmd_type;

   // number of data bytes that follow a voice status
   function automatic logic [1:0] voice_data_bytes(input logic [7:0] status);
      logic [1:0] n;
      n = 2'd0;
      unique case (status[7:4])
         MSG_PROG_CHANGE, MSG_CHAN_PRESS: n = 2'd1;
         MSG_NOTE_OFF, MSG_NOTE_ON, MSG_POLY_PRESS,
         MSG_CTRL_CHANGE, MSG_PITCH_BEND: n = 2'd2;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

### hw/rtl/msp_queue.sv
// ----------------------------------------------------------------------------
// msp_queue
// Two-entry command queue between the parser front end and the back end.
// ----------------------------------------------------------------------------
module msp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  msp_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             q_valid,
   output logic             q_full,
   output msp_pkg::cmd_type q_cmd
);
   import msp_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_full  = (count_ff == 2'd2);
   assign q_cmd   = entry_ff[rd_ptr_ff];

endmodule

### hw/rtl/msp_front.sv
// ----------------------------------------------------------------------------
// msp_front
// Parser front end: takes MIDI bytes, keeps running status and sysex state,
// writes sysex bytes to the store and queues events and sysex drains.
// ----------------------------------------------------------------------------
module msp_front #(
   parameter int unsigned SYSEX_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [4:0]                          csr_listen_channel,
   input  logic                                req_valid,
   input  logic [7:0]                          req_midi_byte,
   output logic                                req_stall,
   input  logic                                q_full,
   input  logic                                drain_done,
   output logic                                push,
   output msp_pkg::cmd_type                    push_cmd,
   output logic                                wr_en,
   output logic [$clog2(SYSEX_DEPTH)-1:0]      wr_addr,
   output logic [7:0]                          wr_data
);
   import msp_pkg::*;

   localparam int unsigned AW = $clog2(SYSEX_DEPTH);
   localparam int unsigned LW = $clog2(SYSEX_DEPTH + 1);

   logic [4:0]    listen_ff;
   logic [7:0]    rs_ff, rs_in;
   logic [1:0]    exp_ff, exp_in;
   logic [1:0]    rcv_ff, rcv_in;
   logic [6:0]    first_ff, first_in;
   logic          in_sysex_ff, in_sysex_in;
   logic [LW-1:0] len_ff, len_in;
   logic          busy_ff, busy_in;

   logic          accept;
   logic          room;
   logic [1:0]    rcv_next;
   logic [4:0]    chan;
   logic [6:0]    key;
   logic [6:0]    val;
   logic [7:0]    b;

   // a pending sysex drain owns the store until the back end has read it
   assign req_stall = q_full || busy_ff;
   assign accept    = req_valid && !req_stall;
   assign b         = req_midi_byte;
   assign room      = (len_ff < LW'(SYSEX_DEPTH));
   assign rcv_next  = rcv_ff + 2'd1;
   assign chan      = {1'b0, rs_ff[3:0]} + 5'd1;
   assign key       = (rcv_ff == 2'd0) ? b[6:0] : first_ff;
   assign val       = (exp_ff == 2'd2) ? b[6:0] : 7'd0;

   // byte classification and parser state update
   always_comb begin
      rs_in       = rs_ff;
      exp_in      = exp_ff;
      rcv_in      = rcv_ff;
      first_in    = first_ff;
      in_sysex_in = in_sysex_ff;
      len_in      = len_ff;
      busy_in     = busy_ff;
      push        = 1'b0;
      push_cmd    = '0;
      wr_en       = 1'b0;
      wr_addr     = len_ff[AW-1:0];
      wr_data     = b;

      if (drain_done) begin
         busy_in = 1'b0;
      end

      if (accept) begin
         priority if (b >= ST_REALTIME) begin
            // real-time bytes pass straight through
            push_cmd.len = LEN_W'(1);
            unique case (b)
               RT_CLOCK: begin
                  push = 1'b1;
                  push_cmd.kind = EV_CLOCK;
               end
               RT_START: begin
                  push = 1'b1;
                  push_cmd.kind = EV_START;
               end
               RT_CONTINUE: begin
                  push = 1'b1;
                  push_cmd.kind = EV_CONTINUE;
               end
               RT_STOP: begin
                  push = 1'b1;
                  push_cmd.kind = EV_STOP;
               end
               default: ;
            endcase
         end else if (b[7]) begin
            // status bytes
            priority if (b == ST_SYSEX_START) begin
               rs_in       = '0;
               exp_in      = '0;
               rcv_in      = '0;
               in_sysex_in = 1'b1;
               wr_en       = 1'b1;
               wr_addr     = '0;
               len_in      = LW'(1);
            end else if (b == ST_SYSEX_END) begin
               rs_in  = '0;
               exp_in = '0;
               rcv_in = '0;
               if (in_sysex_ff) begin
                  in_sysex_in   = 1'b0;
                  wr_en         = room;
                  len_in        = len_ff + LW'(room);
                  push          = 1'b1;
                  push_cmd.is_drain = 1'b1;
                  push_cmd.kind = EV_SYSEX;
                  push_cmd.len  = LEN_W'(len_ff + LW'(room));
                  busy_in       = 1'b1;
               end
            end else begin
               in_sysex_in = 1'b0;
               if (b < ST_SYSEX_START) begin
                  rs_in  = b;
                  exp_in = voice_data_bytes(b);
                  rcv_in = '0;
               end else begin
                  rs_in  = '0;
                  exp_in = '0;
                  rcv_in = '0;
               end
            end
         end else if (in_sysex_ff) begin
            // sysex payload, dropped once the store is full
            if (room) begin
               wr_en  = 1'b1;
               len_in = len_ff + LW'(1);
            end
         end else if (exp_ff != 2'd0) begin
            // data bytes under running status
            if (rcv_ff == 2'd0) begin
               first_in = b[6:0];
            end
            if (rcv_next < exp_ff) begin
               rcv_in = rcv_next;
            end else begin
               rcv_in            = '0;
               push_cmd.chan     = chan;
               push_cmd.key      = key;
               push_cmd.val      = val;
               push_cmd.len      = LEN_W'(1);
               if (chan == listen_ff) begin
                  priority if (rs_ff[7:4] == MSG_NOTE_ON) begin
                     push          = 1'b1;
                     push_cmd.kind = (val == 7'd0) ? EV_NOTE_OFF : EV_NOTE_ON;
                  end else if (rs_ff[7:4] == MSG_NOTE_OFF) begin
                     push          = 1'b1;
                     push_cmd.kind = EV_NOTE_OFF;
                  end else if (rs_ff[7:4] == MSG_CTRL_CHANGE) begin
                     push          = 1'b1;
                     push_cmd.kind = EV_CTRL;
                  end else begin
                     push = 1'b0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_ff   <= 5'd1;
         rs_ff       <= '0;
         exp_ff      <= '0;
         rcv_ff      <= '0;
         first_ff    <= '0;
         in_sysex_ff <= 1'b0;
         len_ff      <= '0;
         busy_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            listen_ff <= csr_listen_channel;
         end
         rs_ff       <= rs_in;
         exp_ff      <= exp_in;
         rcv_ff      <= rcv_in;
         first_ff    <= first_in;
         in_sysex_ff <= in_sysex_in;
         len_ff      <= len_in;
         busy_ff     <= busy_in;
      end
   end

endmodule

### hw/rtl/msp_back.sv
// ----------------------------------------------------------------------------
// msp_back
// Back end: owns the sysex store, takes commands from the queue and delivers
// single events or drains the stored sysex through the output register.
// ----------------------------------------------------------------------------
module msp_back #(
   parameter int unsigned SYSEX_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [$clog2(SYSEX_DEPTH)-1:0] wr_addr,
   input  logic [7:0]                     wr_data,
   input  logic                           q_valid,
   input  msp_pkg::cmd_type               q_cmd,
   output logic                           pop,
   output logic                           drain_done,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_event_kind,
   output logic [4:0]                     rsp_msg_channel,
   output logic [6:0]                     rsp_key_or_controller,
   output logic [6:0]                     rsp_value,
   output logic [7:0]                     rsp_sysex_byte,
   output logic                           rsp_last_of_run
);
   import msp_pkg::*;

   localparam int unsigned AW = $clog2(SYSEX_DEPTH);
   localparam int unsigned LW = $clog2(SYSEX_DEPTH + 1);

   logic [7:0]     mem [SYSEX_DEPTH];
   logic [7:0]     mem_q_ff;

   logic           draining_ff, draining_in;
   logic [LW-1:0]  idx_ff, idx_in;
   logic [LW-1:0]  len_ff, len_in;

   // stage b: event waiting for the output register
   logic           b_valid_ff, b_valid_in;
   event_kind_type b_kind_ff, b_kind_in;
   logic [4:0]     b_chan_ff, b_chan_in;
   logic [6:0]     b_key_ff, b_key_in;
   logic [6:0]     b_val_ff, b_val_in;
   logic           b_sx_ff, b_sx_in;
   logic           b_last_ff, b_last_in;

   // output register
   logic           out_valid_ff;
   logic [2:0]     out_kind_ff;
   logic [4:0]     out_chan_ff;
   logic [6:0]     out_key_ff;
   logic [6:0]     out_val_ff;
   logic [7:0]     out_sx_ff;
   logic           out_last_ff;

   logic           out_free;
   logic           b_free;
   logic           issue;
   logic           issue_last;
   logic [LW-1:0]  idx_next;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign b_free     = !b_valid_ff || out_free;
   assign issue      = draining_ff && b_free;
   assign idx_next   = idx_ff + LW'(1);
   assign issue_last = (idx_next == len_ff);
   assign pop        = !draining_ff && b_free && q_valid;
   assign drain_done = issue && issue_last;

   // command sequencing and drain counter
   always_comb begin
      draining_in = draining_ff;
      idx_in      = idx_ff;
      len_in      = len_ff;
      b_valid_in  = b_valid_ff;
      b_kind_in   = b_kind_ff;
      b_chan_in   = b_chan_ff;
      b_key_in    = b_key_ff;
      b_val_in    = b_val_ff;
      b_sx_in     = b_sx_ff;
      b_last_in   = b_last_ff;

      if (out_free) begin
         b_valid_in = 1'b0;
      end

      if (issue) begin
         b_valid_in = 1'b1;
         b_kind_in  = EV_SYSEX;
         b_chan_in  = '0;
         b_key_in   = '0;
         b_val_in   = '0;
         b_sx_in    = 1'b1;
         b_last_in  = issue_last;
         idx_in     = idx_next;
         if (issue_last) begin
            draining_in = 1'b0;
         end
      end else if (pop) begin
         if (q_cmd.is_drain) begin
            draining_in = 1'b1;
            idx_in      = '0;
            len_in      = LW'(q_cmd.len);
         end else begin
            b_valid_in = 1'b1;
            b_kind_in  = q_cmd.kind;
            b_chan_in  = q_cmd.chan;
            b_key_in   = q_cmd.key;
            b_val_in   = q_cmd.val;
            b_sx_in    = 1'b0;
            b_last_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff <= 1'b0;
         idx_ff      <= '0;
         len_ff      <= '0;
         b_valid_ff  <= 1'b0;
      end else begin
         draining_ff <= draining_in;
         idx_ff      <= idx_in;
         len_ff      <= len_in;
         b_valid_ff  <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_kind_ff <= b_kind_in;
      b_chan_ff <= b_chan_in;
      b_key_ff  <= b_key_in;
      b_val_ff  <= b_val_in;
      b_sx_ff   <= b_sx_in;
      b_last_ff <= b_last_in;
   end

   // sysex store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         mem_q_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_kind_ff <= b_kind_ff;
         out_chan_ff <= b_chan_ff;
         out_key_ff  <= b_key_ff;
         out_val_ff  <= b_val_ff;
         out_sx_ff   <= b_sx_ff ? mem_q_ff : 8'h00;
         out_last_ff <= b_last_ff;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_event_kind        = out_kind_ff;
   assign rsp_msg_channel       = out_chan_ff;
   assign rsp_key_or_controller = out_key_ff;
   assign rsp_value             = out_val_ff;
   assign rsp_sysex_byte        = out_sx_ff;
   assign rsp_last_of_run       = out_last_ff;

`ifndef SYNTHESIS
   // a drain always has at least the start byte to read
   a_drain_len: assert property (@(posedge clock) disable iff (reset)
      draining_ff |-> (len_ff != '0))
      else $error("sysex drain with zero length");

   // the read index stays inside the stored run
   a_drain_idx: assert property (@(posedge clock) disable iff (reset)
      draining_ff |-> (idx_ff < len_ff))
      else $error("sysex read index past run length");

   // the last read ends the drain
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      drain_done |=> !draining_ff)
      else $error("drain still active after last byte");

   // no command is taken while a drain runs
   a_no_pop: assert property (@(posedge clock) disable iff (reset)
      draining_ff |-> !pop)
      else $error("command popped during drain");
`endif

endmodule

### hw/rtl/midi_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// midi_stream_parser_unit
// MIDI byte stream parser with running status, channel filter and sysex
// buffering.
// ----------------------------------------------------------------------------
// The unit takes one MIDI byte per cycle on the req_ channel while req_stall
// is low, and reports note-on, note-off and control-change events on the
// channel set by csr_listen_channel (one-based), real-time clock, start,
// continue and stop at once, and a completed system exclusive message as a
// run of sysex bytes with the final byte marked last. A front end parses
// bytes and queues events in a two-entry queue; a back end delivers them
// through an output register, so input keeps flowing while a result waits.
// After a sysex end byte the input stalls until the back end has read the
// stored run out of its memory, one byte per cycle while the output is not
// stalled. Bytes beyond SYSEX_DEPTH are dropped.
module midi_stream_parser_unit #(
   parameter int unsigned SYSEX_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [4:0] csr_listen_channel,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_midi_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_kind,
   output logic [4:0] rsp_msg_channel,
   output logic [6:0] rsp_key_or_controller,
   output logic [6:0] rsp_value,
   output logic [7:0] rsp_sysex_byte,
   output logic       rsp_last_of_run
);
   import msp_pkg::*;

   localparam int unsigned AW = $clog2(SYSEX_DEPTH);

   logic          q_full;
   logic          q_valid;
   logic          push;
   logic          pop;
   logic          drain_done;
   cmd_type       push_cmd;
   cmd_type       q_cmd;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   // byte parser
   msp_front #(
      .SYSEX_DEPTH (SYSEX_DEPTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_listen_channel (csr_listen_channel),
      .req_valid          (req_valid),
      .req_midi_byte      (req_midi_byte),
      .req_stall          (req_stall),
      .q_full             (q_full),
      .drain_done         (drain_done),
      .push               (push),
      .push_cmd           (push_cmd),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data)
   );

   // command queue
   msp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_full   (q_full),
      .q_cmd    (q_cmd)
   );

   // event delivery and sysex store
   msp_back #(
      .SYSEX_DEPTH (SYSEX_DEPTH)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .wr_en                 (wr_en),
      .wr_addr               (wr_addr),
      .wr_data               (wr_data),
      .q_valid               (q_valid),
      .q_cmd                 (q_cmd),
      .pop                   (pop),
      .drain_done            (drain_done),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_event_kind        (rsp_event_kind),
      .rsp_msg_channel       (rsp_msg_channel),
      .rsp_key_or_controller (rsp_key_or_controller),
      .rsp_value             (rsp_value),
      .rsp_sysex_byte        (rsp_sysex_byte),
      .rsp_last_of_run       (rsp_last_of_run)
   );

endmodule
